FILE: design/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and codes of the circle canvas rasterizer
// Command codes, register indexes, the classified operation handed from
// the front end to the back end, and the result record.
// ----------------------------------------------------------------------------
package ccr_pkg;

   // request command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // shape characters
   localparam logic [7:0] SHAPE_OUTLINE = 8'h63;
   localparam logic [7:0] SHAPE_FILLED  = 8'h43;

   // configuration register indexes
   localparam logic [1:0] CSR_WIDTH      = 2'd0;
   localparam logic [1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [1:0] CSR_BACKGROUND = 2'd2;

   // configuration reset values
   localparam logic [8:0] WIDTH_RESET      = 9'd1;
   localparam logic [8:0] HEIGHT_RESET     = 9'd1;
   localparam logic [7:0] BACKGROUND_RESET = 8'd32;

   // classified operation kinds
   typedef logic [2:0] op_kind_type;
   localparam op_kind_type OP_NOP    = 3'd0;
   localparam op_kind_type OP_CLEAR  = 3'd1;
   localparam op_kind_type OP_DRAW   = 3'd2;
   localparam op_kind_type OP_REJECT = 3'd3;
   localparam op_kind_type OP_READ   = 3'd4;

   typedef struct packed {
      op_kind_type        kind;
      logic               filled;
      logic signed [19:0] center_x;
      logic signed [19:0] center_y;
      logic signed [19:0] radius;
      logic [7:0]         paint_char;
      logic [7:0]         cell_col;
      logic [7:0]         cell_row;
   } op_type;

   typedef struct packed {
      logic [8:0] canvas_width;
      logic [8:0] canvas_height;
      logic [7:0] background_char;
   } cfg_type;

   typedef struct packed {
      logic       status;
      logic [7:0] cell_value;
   } rsp_type;

endpackage

FILE: design/ccr_ram.sv
// ----------------------------------------------------------------------------
// ccr_ram: generic single-port RAM
// One write and one read per cycle at the same address; read data is registered.
// ----------------------------------------------------------------------------
module ccr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/ccr_fifo.sv
// ----------------------------------------------------------------------------
// ccr_fifo: small register queue
// Push/full on the write side, pop/empty on the read side; the head
// entry is shown while empty is low.
// ----------------------------------------------------------------------------
module ccr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ccr_front.sv
// ----------------------------------------------------------------------------
// ccr_front: request intake and classification
// Decode each accepted request into an operation kind (bad circles and
// out-of-storage reads are settled here) and queue it for the back end.
// ----------------------------------------------------------------------------
module ccr_front #(
   parameter int MAX_SIDE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_shape_kind,
   input  logic signed [19:0] req_center_x,
   input  logic signed [19:0] req_center_y,
   input  logic signed [19:0] req_radius,
   input  logic [7:0]         req_paint_char,
   input  logic [7:0]         req_cell_col,
   input  logic [7:0]         req_cell_row,
   output logic               op_valid,
   output ccr_pkg::op_type    op,
   input  logic               op_take
);

   localparam int OPW = $bits(ccr_pkg::op_type);

   ccr_pkg::op_type op_new;
   logic            shape_ok;
   logic            read_ok;
   logic            queue_empty;
   logic [OPW-1:0]  queue_head;

   assign shape_ok = (req_shape_kind == ccr_pkg::SHAPE_OUTLINE) ||
                     (req_shape_kind == ccr_pkg::SHAPE_FILLED);
   assign read_ok  = (32'(req_cell_col) < 32'(MAX_SIDE)) &&
                     (32'(req_cell_row) < 32'(MAX_SIDE));

   always_comb begin
      op_new.filled     = (req_shape_kind == ccr_pkg::SHAPE_FILLED);
      op_new.center_x   = req_center_x;
      op_new.center_y   = req_center_y;
      op_new.radius     = req_radius;
      op_new.paint_char = req_paint_char;
      op_new.cell_col   = req_cell_col;
      op_new.cell_row   = req_cell_row;
      unique case (req_cmd)
         ccr_pkg::CMD_CLEAR: begin
            op_new.kind = ccr_pkg::OP_CLEAR;
         end
         ccr_pkg::CMD_DRAW: begin
            // a radius must be strictly positive
            op_new.kind = (shape_ok && (req_radius > 20'sd0)) ?
                          ccr_pkg::OP_DRAW : ccr_pkg::OP_REJECT;
         end
         ccr_pkg::CMD_READ: begin
            op_new.kind = read_ok ? ccr_pkg::OP_READ : ccr_pkg::OP_NOP;
         end
         default: begin
            op_new.kind = ccr_pkg::OP_NOP;
         end
      endcase
   end

   ccr_fifo #(
      .WIDTH (OPW),
      .DEPTH (2)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (op_new),
      .full      (full),
      .pop       (op_take),
      .pop_data  (queue_head),
      .empty     (queue_empty)
   );

   assign op_valid = !queue_empty;
   assign op       = ccr_pkg::op_type'(queue_head);

endmodule

FILE: design/ccr_back.sv
// ----------------------------------------------------------------------------
// ccr_back: operation engine
// Sweep the canvas for clear and draw, read single cells, and hand one
// result per operation to the result queue. Draw keeps squared distances
// up to date by adds while it walks; the multiplier only runs in setup.
// ----------------------------------------------------------------------------
module ccr_back #(
   parameter int MAX_SIDE  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  ccr_pkg::cfg_type cfg,
   input  logic             op_valid,
   input  ccr_pkg::op_type  op,
   output logic             op_take,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ccr_pkg::rsp_type rsp
);

   localparam int AW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH  = 1 << (2 * AW);
   localparam int CWR    = $clog2(MAX_SIDE + 1);
   localparam int SW     = (CWR > 9) ? CWR : 9;
   localparam int PW     = AW + FRAC_BITS + 1;
   localparam int DW     = ((PW > 21) ? PW : 21) + 1;
   localparam int QW     = 2 * DW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_DRAW  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic signed [20:0]   ONE_R  = 21'sd1 <<< FRAC_BITS;
   localparam logic signed [DW-1:0] ONE_D  = DW'(1) <<< FRAC_BITS;
   localparam logic signed [QW-1:0] ONE_SQ = QW'(1) <<< (2 * FRAC_BITS);

   logic [2:0]            st_ff, st_in;
   ccr_pkg::op_type       op_ff, op_in;
   logic [1:0]            step_ff, step_in;
   logic [AW-1:0]         col_ff, col_in;
   logic [AW-1:0]         row_ff, row_in;
   logic signed [DW-1:0]  dx_ff, dx_in;
   logic signed [DW-1:0]  dy_ff, dy_in;
   logic signed [QW-1:0]  dx2_ff, dx2_in;
   logic signed [QW-1:0]  dy2_ff, dy2_in;
   logic signed [QW-1:0]  cx2_ff, cx2_in;
   logic signed [QW-1:0]  r2_ff, r2_in;
   logic signed [QW-1:0]  inner2_ff, inner2_in;
   logic                  inner_neg_ff, inner_neg_in;
   logic                  status_ff, status_in;
   logic [7:0]            value_ff, value_in;

   logic [SW-1:0]         w_ext, h_ext, side_w, side_h;
   logic                  zero_area, col_last, row_last;
   logic signed [20:0]    inner;
   logic signed [20:0]    mul_a;
   logic signed [41:0]    mul_p;
   logic signed [QW-1:0]  d2;
   logic signed [QW-1:0]  dx2_step, dy2_step;
   logic                  in_disc, rim, paint;
   logic                  ram_we;
   logic [2*AW-1:0]       ram_addr;
   logic [7:0]            ram_wdata, ram_rdata;

   // area in use, clamped to storage
   assign w_ext     = SW'(cfg.canvas_width);
   assign h_ext     = SW'(cfg.canvas_height);
   assign side_w    = (w_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : w_ext;
   assign side_h    = (h_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : h_ext;
   assign zero_area = (side_w == '0) || (side_h == '0);
   assign col_last  = ((SW'(col_ff) + SW'(1)) == side_w);
   assign row_last  = ((SW'(row_ff) + SW'(1)) == side_h);

   // setup multiplier: one square per step
   assign inner = 21'(op_ff.radius) - ONE_R;
   always_comb begin
      case (step_ff)
         2'd0:    mul_a = 21'(op_ff.center_x);
         2'd1:    mul_a = 21'(op_ff.center_y);
         2'd2:    mul_a = 21'(op_ff.radius);
         default: mul_a = inner;
      endcase
   end
   assign mul_p = 42'(mul_a) * 42'(mul_a);

   // per-cell distance test
   assign d2       = dx2_ff + dy2_ff;
   assign in_disc  = (d2 <= r2_ff);
   assign rim      = in_disc && (inner_neg_ff || (d2 > inner2_ff));
   assign paint    = op_ff.filled ? in_disc : rim;
   assign dx2_step = dx2_ff - (QW'(dx_ff) <<< (FRAC_BITS + 1)) + ONE_SQ;
   assign dy2_step = dy2_ff - (QW'(dy_ff) <<< (FRAC_BITS + 1)) + ONE_SQ;

   assign op_take  = (st_ff == S_IDLE) && op_valid;
   assign rsp_push = (st_ff == S_DONE) && !rsp_full;
   assign rsp.status     = status_ff;
   assign rsp.cell_value = value_ff;

   assign ram_we    = (st_ff == S_CLEAR) || ((st_ff == S_DRAW) && paint);
   assign ram_wdata = (st_ff == S_CLEAR) ? cfg.background_char : op_ff.paint_char;
   assign ram_addr  = (st_ff == S_IDLE) ? {AW'(op.cell_row), AW'(op.cell_col)}
                                        : {row_ff, col_ff};

   always_comb begin
      st_in        = st_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      cx2_in       = cx2_ff;
      r2_in        = r2_ff;
      inner2_in    = inner2_ff;
      inner_neg_in = inner_neg_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_in     = op;
               status_in = (op.kind == ccr_pkg::OP_REJECT);
               value_in  = '0;
               col_in    = '0;
               row_in    = '0;
               step_in   = '0;
               case (op.kind)
                  ccr_pkg::OP_CLEAR: st_in = zero_area ? S_DONE : S_CLEAR;
                  ccr_pkg::OP_DRAW:  st_in = S_SETUP;
                  ccr_pkg::OP_READ:  st_in = S_READ;
                  default:           st_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + AW'(1);
               if (row_last) begin
                  st_in = S_DONE;
               end
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
         S_SETUP: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: begin
                  cx2_in = QW'(mul_p);
                  dx2_in = QW'(mul_p);
                  dx_in  = DW'(op_ff.center_x);
                  dy_in  = DW'(op_ff.center_y);
               end
               2'd1: dy2_in = QW'(mul_p);
               2'd2: r2_in  = QW'(mul_p);
               default: begin
                  inner2_in    = QW'(mul_p);
                  inner_neg_in = inner[20];
                  st_in        = zero_area ? S_DONE : S_DRAW;
               end
            endcase
         end
         S_DRAW: begin
            if (col_last) begin
               col_in = '0;
               dx_in  = DW'(op_ff.center_x);
               dx2_in = cx2_ff;
               row_in = row_ff + AW'(1);
               dy_in  = dy_ff - ONE_D;
               dy2_in = dy2_step;
               if (row_last) begin
                  st_in = S_DONE;
               end
            end else begin
               col_in = col_ff + AW'(1);
               dx_in  = dx_ff - ONE_D;
               dx2_in = dx2_step;
            end
         end
         S_READ: begin
            value_in = ram_rdata;
            st_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_full) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
      op_ff        <= op_in;
      step_ff      <= step_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dx2_ff       <= dx2_in;
      dy2_ff       <= dy2_in;
      cx2_ff       <= cx2_in;
      r2_ff        <= r2_in;
      inner2_ff    <= inner2_in;
      inner_neg_ff <= inner_neg_in;
      status_ff    <= status_in;
      value_ff     <= value_in;
   end

   ccr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_canvas (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // sweep stays inside the area in use
   a_sweep_in_area: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLEAR || st_ff == S_DRAW) |->
         (SW'(col_ff) < side_w) && (SW'(row_ff) < side_h))
      else $error("sweep outside canvas area");

   // incremental offsets track the cell position
   a_dx_track: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DRAW) |->
         dx_ff == (DW'(op_ff.center_x) - (DW'(col_ff) << FRAC_BITS)))
      else $error("column offset out of step");

   a_dy_track: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DRAW) |->
         dy_ff == (DW'(op_ff.center_y) - (DW'(row_ff) << FRAC_BITS)))
      else $error("row offset out of step");

   // a rejected circle never touches the canvas
   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      (op_take && op.kind == ccr_pkg::OP_REJECT) |=> (st_ff == S_DONE) && !ram_we)
      else $error("rejected circle reached the canvas");

endmodule

FILE: design/circle_canvas_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_canvas_rasterizer: character canvas with circle fill and outline
// Clear, draw-circle and read-cell commands against an on-chip canvas.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-like port: a transfer happens when push
//   is high and full is low. Results leave the same way: the oldest result
//   sits on rsp_* while empty is low and is taken by pop. One result comes
//   back for every request, in request order.
//   Per request the back end works as follows:
//     clear  : width * height cells, one cell written per cycle
//     draw   : squares x, y, radius, inner radius, then width * height cells
//     read   : registered canvas read
//     reject or unused command: no canvas access
//   A request is held in the request queue before the engine takes it.
//   Clear and draw are paced by the single canvas port, one cell per cycle.
//   Reset empties both queues and loads width 1, height 1 and background
//   32; the canvas itself holds no defined value until cleared or drawn.
//   When pop stays low the result queue fills, the engine holds its last
//   result, and full rises once the request queue has two items waiting.
//   Configuration writes (csr_*) take effect at once; issue them only while
//   no request is outstanding.
// ----------------------------------------------------------------------------
module circle_canvas_rasterizer #(
   parameter int MAX_SIDE  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_shape_kind,
   input  logic signed [19:0] req_center_x,
   input  logic signed [19:0] req_center_y,
   input  logic signed [19:0] req_radius,
   input  logic [7:0]         req_paint_char,
   input  logic [7:0]         req_cell_col,
   input  logic [7:0]         req_cell_row,
   // result channel
   output logic               empty,
   input  logic               pop,
   output logic               rsp_status,
   output logic [7:0]         rsp_cell_value,
   // configuration
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);

   localparam int RSPW = $bits(ccr_pkg::rsp_type);

   ccr_pkg::cfg_type cfg_ff, cfg_in;
   ccr_pkg::op_type  op;
   ccr_pkg::rsp_type rsp_new, rsp_head;
   logic             op_valid, op_take;
   logic             rsp_push, rsp_full;
   logic [RSPW-1:0]  rsp_head_bits;

   // configuration registers: write only, no read-back
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ccr_pkg::CSR_WIDTH:      cfg_in.canvas_width    = csr_wdata;
            ccr_pkg::CSR_HEIGHT:     cfg_in.canvas_height   = csr_wdata;
            ccr_pkg::CSR_BACKGROUND: cfg_in.background_char = csr_wdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width    <= ccr_pkg::WIDTH_RESET;
         cfg_ff.canvas_height   <= ccr_pkg::HEIGHT_RESET;
         cfg_ff.background_char <= ccr_pkg::BACKGROUND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify, then queue
   ccr_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_shape_kind (req_shape_kind),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .req_paint_char (req_paint_char),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .op_valid       (op_valid),
      .op             (op),
      .op_take        (op_take)
   );

   // back: sweep, draw and read the canvas
   ccr_back #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_valid (op_valid),
      .op       (op),
      .op_take  (op_take),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_new)
   );

   // result queue decouples the engine from a stalled receiver
   ccr_fifo #(
      .WIDTH (RSPW),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head_bits),
      .empty     (empty)
   );

   assign rsp_head       = ccr_pkg::rsp_type'(rsp_head_bits);
   assign rsp_status     = rsp_head.status;
   assign rsp_cell_value = rsp_head.cell_value;

endmodule
